@@ sv/spring_distance_constraint_defines.svh @@
// Assertion macros shared by the spring constraint checker.
`ifndef SPRING_DISTANCE_CONSTRAINT_DEFINES_SVH
`define SPRING_DISTANCE_CONSTRAINT_DEFINES_SVH

// Implication checked every clock, masked during reset.
`define SDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spring constraint check failed");

// Condition that must hold on every clock outside reset.
`define SDC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("spring constraint invariant failed");

`endif

@@ sv/sdc_pkg.sv @@
// Types and constants for the spring distance constraint pipeline.
package sdc_pkg;

   localparam int SQ_STEPS = 33;   // root bits
   localparam int DV_STEPS = 35;   // quotient bits
   localparam int LATENCY  = 4 + SQ_STEPS + 4 + DV_STEPS + 2;
   localparam int LANES    = 6;    // three axes times two particles

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_DEGENERATE = 2'd1,
      STATUS_SATURATED  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [2:0][31:0] ad;
      logic [2:0]       dneg;
      logic [23:0]      ima;
      logic [23:0]      imb;
      logic [24:0]      msum;
      logic [30:0]      rest;
   } geom_type;

   typedef struct packed {
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [2:0]       neg;
      logic             degen;
      logic [57:0]      den;
   } tail_type;

endpackage

@@ sv/spring_distance_constraint.sv @@
// Verlet distance constraint between two particles, fully pipelined.
//
// Usage: drive req_* and pulse req_start; an item is taken on every clock
// edge where req_start is high and busy is low. busy never rises, so one
// item can enter every cycle. Each item yields one result beat, marked by
// rsp_strobe for one cycle; results come out in input order. The pipeline
// is made of the bit-per-stage square root (33 stages) and the six parallel
// bit-per-stage dividers (35 stages), plus ten stages of input, difference,
// squaring, length error, multiply, numerator split, rounding and clamping.
// Throughput: one item per clock.
// Degenerate springs (zero length or zero mass sum) return the positions
// unchanged with status 1; clamped results carry status 2.
// Reset (synchronous, active high) drops every item in flight; no result
// beat appears for them. The receiver has no way to stall the output, so
// the pipeline never holds.
module spring_distance_constraint (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start,
   output logic                     busy,
   input  logic signed [31:0]       req_pos_a_x,
   input  logic signed [31:0]       req_pos_a_y,
   input  logic signed [31:0]       req_pos_a_z,
   input  logic signed [31:0]       req_pos_b_x,
   input  logic signed [31:0]       req_pos_b_y,
   input  logic signed [31:0]       req_pos_b_z,
   input  logic        [23:0]       req_inv_mass_a,
   input  logic        [23:0]       req_inv_mass_b,
   input  logic        [30:0]       req_rest_length,
   output logic                     rsp_strobe,
   output logic signed [31:0]       rsp_new_a_x,
   output logic signed [31:0]       rsp_new_a_y,
   output logic signed [31:0]       rsp_new_a_z,
   output logic signed [31:0]       rsp_new_b_x,
   output logic signed [31:0]       rsp_new_b_y,
   output logic signed [31:0]       rsp_new_b_z,
   output sdc_pkg::status_type      rsp_status
);
   import sdc_pkg::*;

   // input register
   logic             in_v_ff;
   logic [2:0][31:0] in_a_ff, in_b_ff;
   logic [23:0]      in_ima_ff, in_imb_ff;
   logic [30:0]      in_rest_ff;

   // deltas
   logic     gm_v_ff;
   geom_type gm_ff, gm_in;

   // squares
   logic             sqr_v_ff;
   logic [2:0][63:0] sqr_ff;
   geom_type         sqr_geom_ff;

   // root pipeline, index 0 holds the radicand
   logic        sq_v_ff    [SQ_STEPS+1];
   logic [66:0] sq_rem_ff  [SQ_STEPS+1];
   logic [32:0] sq_root_ff [SQ_STEPS+1];
   geom_type    sq_geom_ff [SQ_STEPS+1];

   // length error and denominator
   logic        l1_v_ff;
   logic [32:0] l1_ae_ff;
   logic        l1_eneg_ff;
   logic [57:0] l1_den_ff;
   logic        l1_degen_ff;
   geom_type    l1_geom_ff;
   logic [33:0] l1_e;
   logic [32:0] l1_len;

   // |d|*|e|
   logic             l2_v_ff;
   logic [2:0][64:0] l2_p_ff;
   tail_type         l2_tail_ff;
   logic [23:0]      l2_ima_ff, l2_imb_ff;

   // partial products by inverse mass
   logic                    l3_v_ff;
   logic [LANES-1:0][55:0]  l3_pl_ff;
   logic [LANES-1:0][56:0]  l3_ph_ff;
   tail_type                l3_tail_ff;

   // divider pipeline, index 0 holds the numerator split
   logic        dv_v_ff    [DV_STEPS+1];
   logic [57:0] dv_rem_ff  [DV_STEPS+1][LANES];
   logic [34:0] dv_low_ff  [DV_STEPS+1][LANES];
   logic [34:0] dv_q_ff    [DV_STEPS+1][LANES];
   tail_type    dv_tail_ff [DV_STEPS+1];

   // rounded quotients
   logic                   rd_v_ff;
   logic [LANES-1:0][34:0] rd_q_ff;
   tail_type               rd_tail_ff;

   // output
   logic             out_v_ff;
   logic [2:0][31:0] out_a_ff, out_b_ff, out_a_in, out_b_in;
   status_type       out_status_ff, out_status_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= req_start;
      end
   end

   always_ff @(posedge clock) begin
      in_a_ff    <= {req_pos_a_z, req_pos_a_y, req_pos_a_x};
      in_b_ff    <= {req_pos_b_z, req_pos_b_y, req_pos_b_x};
      in_ima_ff  <= req_inv_mass_a;
      in_imb_ff  <= req_inv_mass_b;
      in_rest_ff <= req_rest_length;
   end

   always_comb begin
      logic [32:0] d;
      gm_in      = '0;
      gm_in.a    = in_a_ff;
      gm_in.b    = in_b_ff;
      gm_in.ima  = in_ima_ff;
      gm_in.imb  = in_imb_ff;
      gm_in.rest = in_rest_ff;
      gm_in.msum = {1'b0, in_ima_ff} + {1'b0, in_imb_ff};
      for (int k = 0; k < 3; k++) begin
         d = {in_b_ff[k][31], in_b_ff[k]} - {in_a_ff[k][31], in_a_ff[k]};
         gm_in.dneg[k] = d[32];
         gm_in.ad[k]   = d[32] ? 32'(-d) : d[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gm_v_ff  <= 1'b0;
         sqr_v_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else begin
         gm_v_ff    <= in_v_ff;
         sqr_v_ff   <= gm_v_ff;
         sq_v_ff[0] <= sqr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      gm_ff       <= gm_in;
      sqr_geom_ff <= gm_ff;
      for (int k = 0; k < 3; k++) begin
         sqr_ff[k] <= gm_ff.ad[k] * gm_ff.ad[k];
      end
      sq_rem_ff[0]  <= {3'd0, sqr_ff[0]} + {3'd0, sqr_ff[1]} + {3'd0, sqr_ff[2]};
      sq_root_ff[0] <= '0;
      sq_geom_ff[0] <= sqr_geom_ff;
   end

   // restoring square root, one result bit per stage
   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      localparam int BIT = SQ_STEPS - 1 - i;
      logic [66:0] trial;
      assign trial = ({34'd0, sq_root_ff[i]} << (BIT + 1)) | (67'd1 << (2 * BIT));

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         sq_geom_ff[i+1] <= sq_geom_ff[i];
         if (sq_rem_ff[i] >= trial) begin
            sq_rem_ff[i+1]  <= sq_rem_ff[i] - trial;
            sq_root_ff[i+1] <= sq_root_ff[i] | (33'd1 << BIT);
         end else begin
            sq_rem_ff[i+1]  <= sq_rem_ff[i];
            sq_root_ff[i+1] <= sq_root_ff[i];
         end
      end
   end

   assign l1_len = sq_root_ff[SQ_STEPS];
   assign l1_e   = {1'b0, l1_len} - {3'd0, sq_geom_ff[SQ_STEPS].rest};

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_v_ff    <= 1'b0;
         l2_v_ff    <= 1'b0;
         l3_v_ff    <= 1'b0;
         dv_v_ff[0] <= 1'b0;
      end else begin
         l1_v_ff    <= sq_v_ff[SQ_STEPS];
         l2_v_ff    <= l1_v_ff;
         l3_v_ff    <= l2_v_ff;
         dv_v_ff[0] <= l3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      l1_geom_ff  <= sq_geom_ff[SQ_STEPS];
      l1_eneg_ff  <= l1_e[33];
      l1_ae_ff    <= l1_e[33] ? 33'(-l1_e) : l1_e[32:0];
      l1_den_ff   <= l1_len * sq_geom_ff[SQ_STEPS].msum;
      l1_degen_ff <= (l1_len == '0) || (sq_geom_ff[SQ_STEPS].msum == '0);

      l2_tail_ff.a     <= l1_geom_ff.a;
      l2_tail_ff.b     <= l1_geom_ff.b;
      l2_tail_ff.degen <= l1_degen_ff;
      l2_tail_ff.den   <= l1_den_ff;
      l2_ima_ff        <= l1_geom_ff.ima;
      l2_imb_ff        <= l1_geom_ff.imb;
      for (int k = 0; k < 3; k++) begin
         l2_p_ff[k]        <= l1_geom_ff.ad[k] * l1_ae_ff;
         l2_tail_ff.neg[k] <= l1_geom_ff.dneg[k] ^ l1_eneg_ff;
      end

      l3_tail_ff <= l2_tail_ff;
      for (int k = 0; k < 3; k++) begin
         l3_pl_ff[k]   <= l2_p_ff[k][31:0]  * l2_ima_ff;
         l3_ph_ff[k]   <= l2_p_ff[k][64:32] * l2_ima_ff;
         l3_pl_ff[k+3] <= l2_p_ff[k][31:0]  * l2_imb_ff;
         l3_ph_ff[k+3] <= l2_p_ff[k][64:32] * l2_imb_ff;
      end
   end

   // numerator assembly; the quotient stays below 2^34, so the top bits
   // above the quotient range start out as the partial remainder
   always_ff @(posedge clock) begin
      logic [88:0] n;
      dv_tail_ff[0] <= l3_tail_ff;
      for (int j = 0; j < LANES; j++) begin
         n = {33'd0, l3_pl_ff[j]} + {l3_ph_ff[j], 32'd0};
         dv_rem_ff[0][j] <= {4'd0, n[88:35]};
         dv_low_ff[0][j] <= n[34:0];
         dv_q_ff[0][j]   <= '0;
      end
   end

   // restoring division, one quotient bit per stage in every lane
   for (genvar t = 0; t < DV_STEPS; t++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[t+1] <= 1'b0;
         end else begin
            dv_v_ff[t+1] <= dv_v_ff[t];
         end
      end

      always_ff @(posedge clock) begin
         logic [58:0] rs;
         logic [58:0] dn;
         dv_tail_ff[t+1] <= dv_tail_ff[t];
         dn = {1'b0, dv_tail_ff[t].den};
         for (int j = 0; j < LANES; j++) begin
            rs = {dv_rem_ff[t][j], dv_low_ff[t][j][34]};
            dv_low_ff[t+1][j] <= {dv_low_ff[t][j][33:0], 1'b0};
            if (rs >= dn) begin
               dv_rem_ff[t+1][j] <= 58'(rs - dn);
               dv_q_ff[t+1][j]   <= {dv_q_ff[t][j][33:0], 1'b1};
            end else begin
               dv_rem_ff[t+1][j] <= rs[57:0];
               dv_q_ff[t+1][j]   <= {dv_q_ff[t][j][33:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= dv_v_ff[DV_STEPS];
         out_v_ff <= rd_v_ff;
      end
   end

   // round half away from zero on the magnitude
   always_ff @(posedge clock) begin
      logic rnd;
      rd_tail_ff <= dv_tail_ff[DV_STEPS];
      for (int j = 0; j < LANES; j++) begin
         rnd = {dv_rem_ff[DV_STEPS][j], 1'b0} >= {1'b0, dv_tail_ff[DV_STEPS].den};
         rd_q_ff[j] <= dv_q_ff[DV_STEPS][j] + 35'(rnd);
      end
   end

   always_comb begin
      logic [35:0] va, vb, qa, qb, sa, sb;
      logic        sat;
      sat = 1'b0;
      out_a_in = rd_tail_ff.a;
      out_b_in = rd_tail_ff.b;
      for (int k = 0; k < 3; k++) begin
         sa = {{4{rd_tail_ff.a[k][31]}}, rd_tail_ff.a[k]};
         sb = {{4{rd_tail_ff.b[k][31]}}, rd_tail_ff.b[k]};
         qa = {1'b0, rd_q_ff[k]};
         qb = {1'b0, rd_q_ff[k+3]};
         // A moves with d*e, B against it
         va = rd_tail_ff.neg[k] ? sa - qa : sa + qa;
         vb = rd_tail_ff.neg[k] ? sb + qb : sb - qb;
         if (!va[35] && va[34:31] != 4'h0) begin
            out_a_in[k] = 32'h7FFF_FFFF;
            sat = 1'b1;
         end else if (va[35] && va[34:31] != 4'hF) begin
            out_a_in[k] = 32'h8000_0000;
            sat = 1'b1;
         end else begin
            out_a_in[k] = va[31:0];
         end
         if (!vb[35] && vb[34:31] != 4'h0) begin
            out_b_in[k] = 32'h7FFF_FFFF;
            sat = 1'b1;
         end else if (vb[35] && vb[34:31] != 4'hF) begin
            out_b_in[k] = 32'h8000_0000;
            sat = 1'b1;
         end else begin
            out_b_in[k] = vb[31:0];
         end
      end
      if (rd_tail_ff.degen) begin
         out_a_in      = rd_tail_ff.a;
         out_b_in      = rd_tail_ff.b;
         out_status_in = STATUS_DEGENERATE;
      end else if (sat) begin
         out_status_in = STATUS_SATURATED;
      end else begin
         out_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      out_a_ff      <= out_a_in;
      out_b_ff      <= out_b_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_strobe  = out_v_ff;
   assign rsp_new_a_x = out_a_ff[0];
   assign rsp_new_a_y = out_a_ff[1];
   assign rsp_new_a_z = out_a_ff[2];
   assign rsp_new_b_x = out_b_ff[0];
   assign rsp_new_b_y = out_b_ff[1];
   assign rsp_new_b_z = out_b_ff[2];
   assign rsp_status  = out_status_ff;

endmodule

@@ sv/sdc_checker.sv @@
// Port-level checks for the spring distance constraint, bound to the top.
`include "spring_distance_constraint_defines.svh"

module sdc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_start,
   input logic                busy,
   input logic signed [31:0]  req_pos_a_x,
   input logic signed [31:0]  req_pos_b_z,
   input logic                rsp_strobe,
   input logic signed [31:0]  rsp_new_a_x,
   input logic signed [31:0]  rsp_new_b_z,
   input sdc_pkg::status_type rsp_status
);
   import sdc_pkg::*;

   // every result beat traces back to an accepted item a fixed latency ago
   `SDC_ASSERT_IMPLY(a_beat_has_item, clock, reset, rsp_strobe, $past(req_start, LATENCY) && !$past(busy, LATENCY))

   // an unused status code never shows
   `SDC_ASSERT_IMPLY(a_status_code, clock, reset, rsp_strobe, rsp_status <= STATUS_SATURATED)

   // degenerate springs return the original positions
   `SDC_ASSERT_IMPLY(a_degen_a, clock, reset, rsp_strobe && rsp_status == STATUS_DEGENERATE, rsp_new_a_x == $past(req_pos_a_x, LATENCY))

   `SDC_ASSERT_IMPLY(a_degen_b, clock, reset, rsp_strobe && rsp_status == STATUS_DEGENERATE, rsp_new_b_z == $past(req_pos_b_z, LATENCY))

endmodule

bind spring_distance_constraint sdc_checker u_sdc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_start   (req_start),
   .busy        (busy),
   .req_pos_a_x (req_pos_a_x),
   .req_pos_b_z (req_pos_b_z),
   .rsp_strobe  (rsp_strobe),
   .rsp_new_a_x (rsp_new_a_x),
   .rsp_new_b_z (rsp_new_b_z),
   .rsp_status  (rsp_status)
);
